// ===== rtl/hnu_pkg.sv =====
// Shared constants for the heightmap normal unit.
package hnu_pkg;

    // Default height sample width
    localparam int HEIGHT_BITS_DEF = 16;

    // Vertical scale register, unsigned Q8.16
    localparam int SCALE_W = 24;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 24'd65536;

    // Magnitudes are brought below 2^FIT_W before squaring
    localparam int FIT_W = 31;
    localparam logic [FIT_W-1:0] TWO_Q16 = 31'd131072;

    // Quotient and output formats
    localparam int FRAC_SHIFT = 15;
    localparam int Q_W = 16;
    localparam int OUT_W = 16;
    localparam int Y_W = 15;
    localparam logic [Q_W-1:0] Q15_ONE = 16'd32768;
    localparam logic [Q_W-1:0] OUT_MAX = 16'd32767;

endpackage

// ===== rtl/heightmap_normal_unit.sv =====
// Top level of the heightmap normal unit: pipelined central-difference normal.
//
// Accepts one pixel's four neighbor heights per clock (start high while busy is low;
// busy is never raised) and returns the unit normal, marked by a one-cycle done
// strobe; there is no back-pressure on the result side. For any HEIGHT_BITS, six
// stages form the scaled differences, the common shift and the sum of squares, a
// 32-stage one-bit-per-stage pipeline takes the integer square root, a setup
// register feeds three parallel 16-stage restoring dividers forming the Q1.15
// components, and an output register saturates them. A result is accepted at the
// clock edge that ends its done cycle. The vertical scale register is written over
// the cfg channel; cfg_ready is low while any item is in flight or start is high.
module heightmap_normal_unit
    import hnu_pkg::*;
#(
    parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [HEIGHT_BITS-1:0]  height_left,
    input  logic [HEIGHT_BITS-1:0]  height_right,
    input  logic [HEIGHT_BITS-1:0]  height_below,
    input  logic [HEIGHT_BITS-1:0]  height_above,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [SCALE_W-1:0]      cfg_data,
    output logic                    done,
    output logic signed [OUT_W-1:0] normal_x,
    output logic [Y_W-1:0]          normal_y,
    output logic signed [OUT_W-1:0] normal_z
);

    localparam int PROD_W     = HEIGHT_BITS + SCALE_W;
    localparam int SHIFT_MAX  = PROD_W - FIT_W;
    localparam int K_W        = $clog2(SHIFT_MAX + 1);
    localparam int SQ_W       = 2 * FIT_W;
    localparam int SUM_W      = SQ_W + 2;
    localparam int ROOT_ITERS = SUM_W / 2;
    localparam int LEN_W      = SUM_W / 2;
    localparam int NUM_W      = FIT_W + FRAC_SHIFT + 1;
    localparam int DIV_ITERS  = Q_W;
    localparam int ROOT_BASE  = 5;
    localparam int DIV_BASE   = ROOT_BASE + ROOT_ITERS + 1;
    localparam int OUT_STAGE  = DIV_BASE + DIV_ITERS + 1;
    localparam int PIPE_DEPTH = OUT_STAGE + 1;
    localparam int LANES      = 3;

    logic                   accept;
    logic [PIPE_DEPTH-1:0]  valid_reg;
    logic [SCALE_W-1:0]     scale_reg;

    // Stage 1: difference magnitudes and signs
    logic [HEIGHT_BITS-1:0] dmag_x_reg, dmag_z_reg, dmag_x_next, dmag_z_next;
    logic [LANES-1:0]       s1_neg_reg, s1_neg_next;
    // Stage 2: scaled magnitudes
    logic [PROD_W-1:0]      prod_x_reg, prod_z_reg, prod_x_next, prod_z_next;
    logic [LANES-1:0]       s2_neg_reg;
    // Stage 3: common shift amount
    logic [K_W-1:0]         shamt_reg, shamt_next;
    logic [PROD_W-1:0]      prod3_x_reg, prod3_z_reg;
    logic [LANES-1:0]       s3_neg_reg;
    // Stage 4: shifted magnitudes
    logic [FIT_W-1:0]       fit_reg [0:LANES-1];
    logic [FIT_W-1:0]       fit_next [0:LANES-1];
    logic [LANES-1:0]       s4_neg_reg;
    // Stage 5: squares
    logic [SQ_W-1:0]        sq_reg [0:LANES-1];
    logic [FIT_W-1:0]       s5_fit_reg [0:LANES-1];
    logic [LANES-1:0]       s5_neg_reg;
    // Square root pipeline
    logic [SUM_W-1:0]       rt_v_reg   [0:ROOT_ITERS];
    logic [SUM_W-1:0]       rt_res_reg [0:ROOT_ITERS];
    logic [FIT_W-1:0]       rt_mag_reg [0:ROOT_ITERS][0:LANES-1];
    logic [LANES-1:0]       rt_neg_reg [0:ROOT_ITERS];
    // Divider pipeline
    logic [LEN_W-1:0]       dv_len_reg [0:DIV_ITERS];
    logic [LEN_W-1:0]       dv_r_reg   [0:DIV_ITERS][0:LANES-1];
    logic [Q_W-1:0]         dv_n_reg   [0:DIV_ITERS][0:LANES-1];
    logic [Q_W-1:0]         dv_q_reg   [0:DIV_ITERS][0:LANES-1];
    logic [LANES-1:0]       dv_neg_reg [0:DIV_ITERS];
    // Output stage
    logic [OUT_W-1:0]       normal_x_reg, normal_z_reg, normal_x_next, normal_z_next;
    logic [Y_W-1:0]         normal_y_reg, normal_y_next;

    // Clamp a rounded quotient and attach its sign
    function automatic logic [OUT_W-1:0] sat_signed(input logic [Q_W-1:0] q,
                                                    input logic neg);
        logic [Q_W-1:0] lim;
        begin
            if (neg)
            begin
                lim = (q > Q15_ONE) ? Q15_ONE : q;
                sat_signed = OUT_W'(Q_W'(0) - lim);
            end
            else
            begin
                sat_signed = OUT_W'((q > OUT_MAX) ? OUT_MAX : q);
            end
        end
    endfunction

    // Handshake: the pipeline never stalls
    assign accept    = start && !busy;
    assign busy      = 1'b0;
    assign cfg_ready = ~(|valid_reg) && !start;

    // Advance valid bits with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[PIPE_DEPTH-2:0], accept};
        end
    end

    // Hold the vertical scale, update on a cfg transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= SCALE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            scale_reg <= cfg_data;
        end
    end

    // Stage 1: form difference magnitudes
    always_comb
    begin
        dmag_x_next = (height_left >= height_right) ? (height_left - height_right)
                                                    : (height_right - height_left);
        dmag_z_next = (height_below >= height_above) ? (height_below - height_above)
                                                     : (height_above - height_below);
        s1_neg_next = {height_below < height_above, 1'b0, height_left < height_right};
    end

    // Stage 2: apply the scale
    always_comb
    begin
        prod_x_next = PROD_W'(dmag_x_reg) * PROD_W'(scale_reg);
        prod_z_next = PROD_W'(dmag_z_reg) * PROD_W'(scale_reg);
    end

    // Stage 3: find the least shift that fits every magnitude
    always_comb
    begin
        logic [PROD_W-1:0] big;
        big        = prod_x_reg | prod_z_reg;
        shamt_next = '0;
        for (int i = FIT_W; i < PROD_W; i++)
        begin
            if (big[i])
            begin
                shamt_next = K_W'(i - FIT_W + 1);
            end
        end
    end

    // Stage 4: apply the common shift
    always_comb
    begin
        logic [PROD_W-1:0] sx;
        logic [PROD_W-1:0] sz;
        sx          = prod3_x_reg >> shamt_reg;
        sz          = prod3_z_reg >> shamt_reg;
        fit_next[0] = sx[FIT_W-1:0];
        fit_next[1] = TWO_Q16 >> shamt_reg;
        fit_next[2] = sz[FIT_W-1:0];
    end

    // Front stages
    always_ff @(posedge clk)
    begin
        dmag_x_reg  <= dmag_x_next;
        dmag_z_reg  <= dmag_z_next;
        s1_neg_reg  <= s1_neg_next;
        prod_x_reg  <= prod_x_next;
        prod_z_reg  <= prod_z_next;
        s2_neg_reg  <= s1_neg_reg;
        shamt_reg   <= shamt_next;
        prod3_x_reg <= prod_x_reg;
        prod3_z_reg <= prod_z_reg;
        s3_neg_reg  <= s2_neg_reg;
        fit_reg     <= fit_next;
        s4_neg_reg  <= s3_neg_reg;
        for (int l = 0; l < LANES; l++)
        begin
            sq_reg[l] <= SQ_W'(fit_reg[l]) * SQ_W'(fit_reg[l]);
        end
        s5_fit_reg  <= fit_reg;
        s5_neg_reg  <= s4_neg_reg;
        // Stage 6: sum of squares enters the root pipeline
        rt_v_reg[0]   <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
        rt_res_reg[0] <= '0;
        rt_mag_reg[0] <= s5_fit_reg;
        rt_neg_reg[0] <= s5_neg_reg;
    end

    // Square root: one result bit per stage
    for (genvar j = 0; j < ROOT_ITERS; j++)
    begin : g_root
        localparam int BIT_POS = SUM_W - 2 - 2 * j;
        localparam logic [SUM_W-1:0] ROOT_BIT = SUM_W'(1) << BIT_POS;

        logic [SUM_W-1:0] trial;
        logic [SUM_W-1:0] v_next;
        logic [SUM_W-1:0] res_next;

        always_comb
        begin
            trial = rt_res_reg[j] + ROOT_BIT;
            if (rt_v_reg[j] >= trial)
            begin
                v_next   = rt_v_reg[j] - trial;
                res_next = (rt_res_reg[j] >> 1) + ROOT_BIT;
            end
            else
            begin
                v_next   = rt_v_reg[j];
                res_next = rt_res_reg[j] >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            rt_v_reg[j+1]   <= v_next;
            rt_res_reg[j+1] <= res_next;
            rt_mag_reg[j+1] <= rt_mag_reg[j];
            rt_neg_reg[j+1] <= rt_neg_reg[j];
        end
    end

    // Divider setup: rounded numerator split into leading remainder and low bits
    always_ff @(posedge clk)
    begin
        logic [LEN_W-1:0] len;
        logic [NUM_W-1:0] num;
        len = rt_res_reg[ROOT_ITERS][LEN_W-1:0];
        if (len == '0)
        begin
            len = LEN_W'(1);
        end
        dv_len_reg[0] <= len;
        dv_neg_reg[0] <= rt_neg_reg[ROOT_ITERS];
        for (int l = 0; l < LANES; l++)
        begin
            num = (NUM_W'(rt_mag_reg[ROOT_ITERS][l]) << FRAC_SHIFT) + NUM_W'(len >> 1);
            dv_r_reg[0][l] <= LEN_W'(num[NUM_W-1:Q_W]);
            dv_n_reg[0][l] <= num[Q_W-1:0];
            dv_q_reg[0][l] <= '0;
        end
    end

    // Restoring division: one quotient bit per stage in each lane
    for (genvar i = 0; i < DIV_ITERS; i++)
    begin : g_div
        logic [LEN_W:0]   trial [0:LANES-1];
        logic [LEN_W-1:0] r_next [0:LANES-1];
        logic [Q_W-1:0]   q_next [0:LANES-1];

        always_comb
        begin
            for (int l = 0; l < LANES; l++)
            begin
                trial[l] = {dv_r_reg[i][l], dv_n_reg[i][l][Q_W-1]};
                if (trial[l] >= {1'b0, dv_len_reg[i]})
                begin
                    r_next[l] = LEN_W'(trial[l] - {1'b0, dv_len_reg[i]});
                    q_next[l] = {dv_q_reg[i][l][Q_W-2:0], 1'b1};
                end
                else
                begin
                    r_next[l] = trial[l][LEN_W-1:0];
                    q_next[l] = {dv_q_reg[i][l][Q_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            dv_len_reg[i+1] <= dv_len_reg[i];
            dv_neg_reg[i+1] <= dv_neg_reg[i];
            dv_r_reg[i+1]   <= r_next;
            dv_q_reg[i+1]   <= q_next;
            for (int l = 0; l < LANES; l++)
            begin
                dv_n_reg[i+1][l] <= {dv_n_reg[i][l][Q_W-2:0], 1'b0};
            end
        end
    end

    // Output stage: saturate and attach signs
    always_comb
    begin
        normal_x_next = sat_signed(dv_q_reg[DIV_ITERS][0], dv_neg_reg[DIV_ITERS][0]);
        normal_y_next = Y_W'((dv_q_reg[DIV_ITERS][1] > OUT_MAX) ? OUT_MAX
                                                                : dv_q_reg[DIV_ITERS][1]);
        normal_z_next = sat_signed(dv_q_reg[DIV_ITERS][2], dv_neg_reg[DIV_ITERS][2]);
    end

    always_ff @(posedge clk)
    begin
        normal_x_reg <= normal_x_next;
        normal_y_reg <= normal_y_next;
        normal_z_reg <= normal_z_next;
    end

    assign done     = valid_reg[PIPE_DEPTH-1];
    assign normal_x = normal_x_reg;
    assign normal_y = normal_y_reg;
    assign normal_z = normal_z_reg;

    // Every accepted item produces its done strobe at the end of the pipeline
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##PIPE_DEPTH done)
        else $error("result strobe does not match accepted item");

    // Config port stays closed while a result is being delivered
    a_cfg_closed: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !cfg_ready)
        else $error("cfg port open while items are in flight");

    // The root of a valid item is never zero
    a_root_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[DIV_BASE-1] |-> (rt_res_reg[ROOT_ITERS] != '0))
        else $error("zero vector length");

    // Rounded quotients never exceed one in Q1.15
    a_quot_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[OUT_STAGE-1] |-> ((dv_q_reg[DIV_ITERS][0] <= Q15_ONE)
                                 && (dv_q_reg[DIV_ITERS][1] <= Q15_ONE)
                                 && (dv_q_reg[DIV_ITERS][2] <= Q15_ONE)))
        else $error("quotient out of range");

endmodule
